### src/assert_macros.svh
// assertion macros shared by the culling rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### src/sfc_pkg.sv
// types, constants and the square root digit step for the sphere culler
// no dependencies
package sfc_pkg;

  localparam int unsigned NUM_PLANES   = 6;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = CFG_IDX_W'(NUM_PLANES - 1);

  localparam int unsigned COORD_W      = 24;
  localparam int unsigned NORM_W       = 12;
  localparam int unsigned OFF_W        = 28;
  localparam int unsigned OFF_LSB      = 36;
  localparam int unsigned PLANE_W      = 64;

  // square root of (max squared scale << 12): 36-bit radicand, 18-bit root
  localparam int unsigned RADICAND_W   = 36;
  localparam int unsigned ROOT_W       = 18;
  localparam int unsigned REM_W        = 21;
  localparam int unsigned DIG_PER_STG  = 3;
  localparam int unsigned SQ_STAGES    = ROOT_W / DIG_PER_STG;

  localparam int unsigned RAD_SC_W     = COORD_W + ROOT_W;  // Q22.20
  localparam int unsigned PROD_W       = NORM_W + COORD_W;
  localparam int unsigned DOT_W        = PROD_W + 2;
  localparam int unsigned ACC_W        = 46;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic        [COORD_W-1:0] rad;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]      rem;
    logic [ROOT_W-1:0]     root;
    logic [RADICAND_W-1:0] v;
  } sq_t;

  // one restoring digit: bring down two radicand bits, try (root*4 + 1)
  function automatic sq_t sqrt_digit(sq_t s);
    sq_t              r;
    logic [REM_W-1:0] rem_s;
    logic [REM_W-1:0] trial;
    rem_s = {s.rem[REM_W-3:0], s.v[RADICAND_W-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    r.v   = {s.v[RADICAND_W-3:0], 2'b00};
    if (rem_s >= trial) begin
      r.rem  = rem_s - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = rem_s;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic sq_t sqrt_stage(sq_t s);
    sq_t r;
    r = s;
    for (int i = 0; i < DIG_PER_STG; i++) begin
      r = sqrt_digit(r);
    end
    return r;
  endfunction

endpackage

### src/sphere_frustum_cull_top.sv
// sphere against six-plane frustum test: scale root, scaled radius, plane distances
// depends on sfc_pkg, sfc_sqrt_pipe and assert_macros.svh
//
//   port group   dir   handshake                 words
//   in_*         in    in_valid_i / in_ready_o   centre, radius, squared scales
//   out_*        out   out_valid_o / out_ready_i in_frustum
//   cfg_*        in    cfg_we_i, no wait         plane registers 0..5
//
// one sphere per cycle while out_ready_i does not hold the output
// each word passes the six root stages, then the product, sum and compare stages
// every stage holds its word under stall and fills bubbles while the output waits
// reset clears the plane registers and all valid bits
`include "assert_macros.svh"

module sphere_frustum_cull_top
  import sfc_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [COORD_W-1:0]   center_x_i,
  input  logic signed [COORD_W-1:0]   center_y_i,
  input  logic signed [COORD_W-1:0]   center_z_i,
  input  logic        [COORD_W-1:0]   radius_i,
  input  logic        [COORD_W-1:0]   scale_sq_x_i,
  input  logic        [COORD_W-1:0]   scale_sq_y_i,
  input  logic        [COORD_W-1:0]   scale_sq_z_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        in_frustum_o,
  input  logic                        cfg_we_i,
  input  logic        [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic        [PLANE_W-1:0]   cfg_wdata_i
);

  logic [PLANE_W-1:0] planes_q [NUM_PLANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        planes_q[i] <= '0;
      end
    end else if (cfg_we_i && cfg_idx_i <= CFG_IDX_LAST) begin
      planes_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // largest squared scale
  logic [COORD_W-1:0] mx_xy, mx;
  side_t              side_in;

  assign mx_xy = (scale_sq_y_i > scale_sq_x_i) ? scale_sq_y_i : scale_sq_x_i;
  assign mx    = (scale_sq_z_i > mx_xy) ? scale_sq_z_i : mx_xy;

  assign side_in.cx  = center_x_i;
  assign side_in.cy  = center_y_i;
  assign side_in.cz  = center_z_i;
  assign side_in.rad = radius_i;

  logic              sq_valid, sq_ready;
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;

  sfc_sqrt_pipe u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_mx_i     (mx),
    .in_side_i   (side_in),
    .out_valid_o (sq_valid),
    .out_ready_i (sq_ready),
    .out_root_o  (sq_root),
    .out_side_o  (sq_side)
  );

  // stage ready chain for product, sum and output stages
  logic vm_q, va_q, vo_q;
  logic rdy_m, rdy_a, rdy_o;

  assign rdy_o    = !vo_q || out_ready_i;
  assign rdy_a    = !va_q || rdy_o;
  assign rdy_m    = !vm_q || rdy_a;
  assign sq_ready = rdy_m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      va_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy_m) vm_q <= sq_valid;
      if (rdy_a) va_q <= vm_q;
      if (rdy_o) vo_q <= va_q;
    end
  end

  // product stage: scaled radius and three normal products per plane
  logic        [RAD_SC_W-1:0] r20_q;
  logic signed [PROD_W-1:0]   px_q [NUM_PLANES];
  logic signed [PROD_W-1:0]   py_q [NUM_PLANES];
  logic signed [PROD_W-1:0]   pz_q [NUM_PLANES];

  always_ff @(posedge clk_i) begin
    if (rdy_m) begin
      r20_q <= RAD_SC_W'(sq_side.rad) * RAD_SC_W'(sq_root);
      for (int i = 0; i < NUM_PLANES; i++) begin
        px_q[i] <= PROD_W'($signed(planes_q[i][NORM_W-1:0])) * PROD_W'(sq_side.cx);
        py_q[i] <= PROD_W'($signed(planes_q[i][2*NORM_W-1:NORM_W])) * PROD_W'(sq_side.cy);
        pz_q[i] <= PROD_W'($signed(planes_q[i][3*NORM_W-1:2*NORM_W])) * PROD_W'(sq_side.cz);
      end
    end
  end

  // sum stage: dot product, and scaled radius minus offset at 20 fraction bits
  logic signed [DOT_W-1:0] dot_q  [NUM_PLANES];
  logic signed [ACC_W-1:0] bias_q [NUM_PLANES];

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        dot_q[i]  <= DOT_W'(px_q[i]) + DOT_W'(py_q[i]) + DOT_W'(pz_q[i]);
        bias_q[i] <= $signed(ACC_W'(r20_q))
                     - (ACC_W'($signed(planes_q[i][OFF_LSB +: OFF_W])) <<< 12);
      end
    end
  end

  // compare stage: 4*dot - 4096*off + r20 must be positive on every plane
  logic                    inside_d;
  logic                    inside_q;
  logic signed [ACC_W-1:0] margin [NUM_PLANES];

  always_comb begin
    inside_d = 1'b1;
    for (int i = 0; i < NUM_PLANES; i++) begin
      margin[i] = (ACC_W'(dot_q[i]) <<< 2) + bias_q[i];
      if (margin[i] <= 0) inside_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o) inside_q <= inside_d;
  end

  assign out_valid_o  = vo_q;
  assign in_frustum_o = inside_q;

  `ASSERT_CLK(a_blocked_means_full, !in_ready_o |-> (out_valid_o && vm_q && va_q), "input blocked with a free stage")
  `ASSERT_CLK(a_sum_holds, (va_q && !rdy_a) |=> va_q, "stalled sum word lost")
  `ASSERT_NEVER(a_no_drop, sq_valid && sq_ready && vm_q && !rdy_a, "product stage overwritten")

endmodule

### src/sfc_sqrt_pipe.sv
// pipelined integer square root, three root bits per stage, with sideband words
// depends on sfc_pkg and assert_macros.svh
`include "assert_macros.svh"

module sfc_sqrt_pipe
  import sfc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [COORD_W-1:0] in_mx_i,
  input  side_t              in_side_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ROOT_W-1:0]  out_root_o,
  output side_t              out_side_o
);

  logic [SQ_STAGES-1:0] v_q;
  logic [SQ_STAGES:0]   rdy;
  sq_t                  sq_q   [SQ_STAGES];
  side_t                side_q [SQ_STAGES];
  sq_t                  sq_in;

  // a stage takes a word when it is empty or its word moves on
  always_comb begin
    rdy[SQ_STAGES] = out_ready_i;
    for (int k = SQ_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign sq_in.rem  = '0;
  assign sq_in.root = '0;
  assign sq_in.v    = {in_mx_i, 12'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < SQ_STAGES; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      sq_q[0]   <= sqrt_stage(sq_in);
      side_q[0] <= in_side_i;
    end
    for (int k = 1; k < SQ_STAGES; k++) begin
      if (rdy[k]) begin
        sq_q[k]   <= sqrt_stage(sq_q[k-1]);
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[SQ_STAGES-1];
  assign out_root_o  = sq_q[SQ_STAGES-1].root;
  assign out_side_o  = side_q[SQ_STAGES-1];

  `ASSERT_CLK(a_full_when_blocked, !in_ready_o |-> (&v_q), "sqrt pipe blocked with a bubble")
  `ASSERT_CLK(a_last_holds, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_root_o)), "stalled root changed")

endmodule

### tb/sv/tb_sphere_frustum_cull_top.sv
// testbench for sphere_frustum_cull_top: directed probes, then random spheres over
// random and fixed plane sets, checked by table or in-bench predictor; needs sfc_pkg
`timescale 1ns / 1ps

module tb_sphere_frustum_cull_top;
  import sfc_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_LEFT, IDX_RIGHT, IDX_TOP, IDX_BOTTOM, IDX_NEAR, IDX_FAR, IDX_SPARE_A, IDX_SPARE_B
  } plane_idx_e;

  typedef enum int {
    PH_BOX, PH_RANDOM, PH_ALL_ONES, PH_BOX_QUIET, PH_EXTREMES, PH_SPARE, PH_COUNT
  } phase_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic        [COORD_W-1:0] rad;
    logic        [COORD_W-1:0] sx;
    logic        [COORD_W-1:0] sy;
    logic        [COORD_W-1:0] sz;
  } sphere_t;

  typedef struct packed {
    logic    box;    // row runs against the fixed directed box
    sphere_t s;
    logic    known;
    logic    exp_in;
  } probe_t;

  localparam int MAXS  = 8388607;
  localparam int MINS  = -8388608;
  localparam int MAXU  = 16777215;
  localparam int ONE_SQ = 4096;      // 1.0 in Q12.12
  localparam int BOX_H = 25600;      // 100.0 in Q16.8
  localparam int N_PROBES = 20;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int SETTLE = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic signed [NORM_W-1:0] N_ONE = 12'sd1024;
  localparam logic signed [NORM_W-1:0] N_MAX = 12'sd2047;
  localparam logic signed [NORM_W-1:0] N_MIN = -12'sd2048;
  localparam logic signed [OFF_W-1:0]  OFF_MAX = 28'sh7ffffff;
  localparam logic signed [OFF_W-1:0]  OFF_MIN = -28'sh8000000;

  localparam probe_t PROBES [N_PROBES] = '{
    '{1'b0, '{0, 0, 0, 0, 0, 0, 0}, 1'b1, 1'b0},
    '{1'b0, '{0, 0, 0, MAXU, 0, 0, 0}, 1'b1, 1'b0},
    '{1'b0, '{0, 0, 0, 1, ONE_SQ, 0, 0}, 1'b1, 1'b1},
    '{1'b0, '{0, 0, 0, MAXU, MAXU, MAXU, MAXU}, 1'b1, 1'b1},
    '{1'b0, '{MAXS, MAXS, MAXS, 0, MAXU, MAXU, MAXU}, 1'b1, 1'b0},
    '{1'b0, '{MINS, MINS, MINS, 1, 0, MAXU, 0}, 1'b1, 1'b1},
    '{1'b0, '{MINS, MAXS, 0, 8388608, 0, 0, 1}, 1'b1, 1'b1},
    '{1'b0, '{12345, -54321, 777, 5921370, 2, 3, 10855845}, 1'b0, 1'b0},
    '{1'b1, '{0, 0, 0, 0, 0, 0, 0}, 1'b1, 1'b1},
    '{1'b1, '{BOX_H, 0, 0, 0, ONE_SQ, ONE_SQ, ONE_SQ}, 1'b1, 1'b0},
    '{1'b1, '{BOX_H, 0, 0, 1, ONE_SQ, 0, 0}, 1'b1, 1'b1},
    '{1'b1, '{BOX_H + 256, 0, 0, 256, ONE_SQ, 0, 0}, 1'b1, 1'b0},
    '{1'b1, '{BOX_H + 256, 0, 0, 257, ONE_SQ, 0, 0}, 1'b1, 1'b1},
    '{1'b1, '{0, -BOX_H - 1, 0, 0, 0, 0, 0}, 1'b1, 1'b0},
    '{1'b1, '{0, 0, -BOX_H, 0, 0, 0, 0}, 1'b1, 1'b0},
    '{1'b1, '{0, 0, BOX_H - 1, 0, 0, 0, 0}, 1'b1, 1'b1},
    '{1'b1, '{MAXS, MAXS, MAXS, MAXU, MAXU, MAXU, MAXU}, 1'b0, 1'b0},
    '{1'b1, '{MINS, 0, MAXS, MAXU, 0, MAXU, 0}, 1'b0, 1'b0},
    '{1'b1, '{-BOX_H, -BOX_H, BOX_H, 181, 2, 8191, 3}, 1'b0, 1'b0},
    '{1'b1, '{100, 200, -300, 1000, MAXU, 0, 1}, 1'b0, 1'b0}
  };

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [COORD_W-1:0]  center_x_i = '0;
  logic signed [COORD_W-1:0]  center_y_i = '0;
  logic signed [COORD_W-1:0]  center_z_i = '0;
  logic        [COORD_W-1:0]  radius_i = '0;
  logic        [COORD_W-1:0]  scale_sq_x_i = '0;
  logic        [COORD_W-1:0]  scale_sq_y_i = '0;
  logic        [COORD_W-1:0]  scale_sq_z_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic                       in_frustum_o;
  logic                       cfg_we_i = 1'b0;
  logic        [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic        [PLANE_W-1:0]  cfg_wdata_i = '0;

  logic [PLANE_W-1:0] plane_reg [NUM_PLANES];
  logic               inside_q [$];
  logic               pend_inside = 1'b0;
  logic               idle_en = 1'b1;
  logic               got_inside;
  int                 n_sent = 0;
  int                 n_inside = 0;
  int                 n_outside = 0;
  int                 n_errors = 0;
  int                 quiet_cycles = 0;
  int                 hx = BOX_H;
  int                 hy = BOX_H;
  int                 hz = BOX_H;

  sphere_frustum_cull_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .center_z_i   (center_z_i),
    .radius_i     (radius_i),
    .scale_sq_x_i (scale_sq_x_i),
    .scale_sq_y_i (scale_sq_y_i),
    .scale_sq_z_i (scale_sq_z_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .in_frustum_o (in_frustum_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // floor of sqrt(sq * 4096), built bit by bit from the top
  function automatic logic [ROOT_W-1:0] scale_root(logic [COORD_W-1:0] sq);
    logic [RADICAND_W-1:0] radicand;
    logic [ROOT_W-1:0]     root;
    logic [ROOT_W-1:0]     trial;
    logic [RADICAND_W-1:0] trial_sq;
    int                    b;
    radicand = {sq, 12'd0};
    root = '0;
    for (b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (ROOT_W'(1) << b);
      trial_sq = trial * trial;
      if (trial_sq <= radicand) root = trial;
    end
    return root;
  endfunction

  function automatic logic sphere_inside(sphere_t s);
    logic [COORD_W-1:0] max_sq;
    longint             r20;
    longint             nx;
    longint             ny;
    longint             nz;
    longint             off;
    longint             d18;
    logic               all_front;
    max_sq = s.sx;
    if (s.sy > max_sq) max_sq = s.sy;
    if (s.sz > max_sq) max_sq = s.sz;
    r20 = longint'(s.rad) * longint'(scale_root(max_sq));
    all_front = 1'b1;
    for (int i = 0; i < NUM_PLANES; i++) begin
      nx  = longint'($signed(plane_reg[i][NORM_W-1:0]));
      ny  = longint'($signed(plane_reg[i][2*NORM_W-1:NORM_W]));
      nz  = longint'($signed(plane_reg[i][3*NORM_W-1:2*NORM_W]));
      off = longint'($signed(plane_reg[i][PLANE_W-1:OFF_LSB]));
      d18 = nx * longint'(s.cx) + ny * longint'(s.cy) + nz * longint'(s.cz) - off * 1024;
      if (!(d18 * 4 > -r20)) all_front = 1'b0;
    end
    return all_front;
  endfunction

  function automatic logic [PLANE_W-1:0] make_plane(logic signed [NORM_W-1:0] nx,
      logic signed [NORM_W-1:0] ny, logic signed [NORM_W-1:0] nz,
      logic signed [OFF_W-1:0] off);
    return {off, nz, ny, nx};
  endfunction

  function automatic sphere_t rand_sphere(logic near);
    sphere_t s;
    int      hmin;
    hmin = (hx < hy) ? hx : hy;
    hmin = (hz < hmin) ? hz : hmin;
    if (near) begin
      s.cx  = COORD_W'(int'($urandom_range(4 * hx)) - 2 * hx);
      s.cy  = COORD_W'(int'($urandom_range(4 * hy)) - 2 * hy);
      s.cz  = COORD_W'(int'($urandom_range(4 * hz)) - 2 * hz);
      s.rad = COORD_W'($urandom_range(hmin / 2));
      s.sx  = COORD_W'($urandom_range(4 * ONE_SQ));
      s.sy  = COORD_W'($urandom_range(4 * ONE_SQ));
      s.sz  = COORD_W'($urandom_range(4 * ONE_SQ));
    end else begin
      s.cx  = COORD_W'($urandom);
      s.cy  = COORD_W'($urandom);
      s.cz  = COORD_W'($urandom);
      s.rad = COORD_W'($urandom);
      s.sx  = COORD_W'($urandom);
      s.sy  = COORD_W'($urandom);
      s.sz  = COORD_W'($urandom);
    end
    return s;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    n_errors++;
  endtask

  // caller lowers cfg_we_i after the last write of a batch
  task automatic write_reg(input plane_idx_e idx, input logic [PLANE_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    if (idx < NUM_PLANES) plane_reg[idx] = data;
    @(negedge clk_i);
  endtask

  task automatic load_box(input int ex, input int ey, input int ez);
    hx = ex;
    hy = ey;
    hz = ez;
    write_reg(IDX_LEFT,   make_plane(N_ONE, '0, '0, OFF_W'(-ex)));
    write_reg(IDX_RIGHT,  make_plane(-N_ONE, '0, '0, OFF_W'(-ex)));
    write_reg(IDX_TOP,    make_plane('0, -N_ONE, '0, OFF_W'(-ey)));
    write_reg(IDX_BOTTOM, make_plane('0, N_ONE, '0, OFF_W'(-ey)));
    write_reg(IDX_NEAR,   make_plane('0, '0, N_ONE, OFF_W'(-ez)));
    write_reg(IDX_FAR,    make_plane('0, '0, -N_ONE, OFF_W'(-ez)));
  endtask

  task automatic wait_idle();
    while (inside_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // entered just after a falling edge; leaves valid high after the word is taken
  task automatic send_sphere(input sphere_t s, input logic known, input logic exp_in);
    int seen;
    while (idle_en && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    center_x_i   <= s.cx;
    center_y_i   <= s.cy;
    center_z_i   <= s.cz;
    radius_i     <= s.rad;
    scale_sq_x_i <= s.sx;
    scale_sq_y_i <= s.sy;
    scale_sq_z_i <= s.sz;
    pend_inside  <= known ? exp_in : sphere_inside(s);
    seen = n_sent;
    do @(negedge clk_i); while (n_sent == seen);
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= !(idle_en && $urandom_range(99) < 7);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        inside_q.push_back(pend_inside);
        n_sent++;
      end
      if (out_valid_o && out_ready_i) begin
        if (inside_q.size() == 0) begin
          report_mismatch($sformatf("result %0b with nothing pending", in_frustum_o));
        end else begin
          got_inside = inside_q.pop_front();
          if (in_frustum_o !== got_inside)
            report_mismatch($sformatf("in_frustum %0b, expected %0b",
                                      in_frustum_o, got_inside));
          if (got_inside) n_inside++;
          else n_outside++;
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic box_loaded;
    int   k;
    box_loaded = 1'b0;
    for (int i = 0; i < NUM_PLANES; i++) plane_reg[i] = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed probes, reset planes first, then a fixed box
    for (int p = 0; p < N_PROBES; p++) begin
      if (PROBES[p].box && !box_loaded) begin
        in_valid_i <= 1'b0;
        wait_idle();
        load_box(BOX_H, BOX_H, BOX_H);
        cfg_we_i <= 1'b0;
        box_loaded = 1'b1;
      end
      send_sphere(PROBES[p].s, PROBES[p].known, PROBES[p].exp_in);
    end
    in_valid_i <= 1'b0;

    for (int ph = 0; ph < PH_COUNT; ph++) begin
      wait_idle();
      case (phase_e'(ph))
        PH_BOX, PH_BOX_QUIET: begin
          load_box($urandom_range(4000000, 256), $urandom_range(4000000, 256),
                   $urandom_range(4000000, 256));
        end
        PH_RANDOM: begin
          write_reg(IDX_LEFT,   {$urandom, $urandom});
          write_reg(IDX_RIGHT,  {$urandom, $urandom});
          write_reg(IDX_TOP,    {$urandom, $urandom});
          write_reg(IDX_BOTTOM, {$urandom, $urandom});
          write_reg(IDX_NEAR,   {$urandom, $urandom});
          write_reg(IDX_FAR,    {$urandom, $urandom});
        end
        PH_ALL_ONES: begin
          // every normal component and offset at -1 lsb
          write_reg(IDX_LEFT,   '1);
          write_reg(IDX_RIGHT,  '1);
          write_reg(IDX_TOP,    '1);
          write_reg(IDX_BOTTOM, '1);
          write_reg(IDX_NEAR,   '1);
          write_reg(IDX_FAR,    '1);
        end
        PH_EXTREMES: begin
          write_reg(IDX_LEFT,   make_plane(N_MAX, N_MAX, N_MAX, OFF_MAX));
          write_reg(IDX_RIGHT,  make_plane(N_MIN, N_MIN, N_MIN, OFF_MIN));
          write_reg(IDX_TOP,    make_plane(N_MAX, N_MIN, '0, OFF_MIN));
          write_reg(IDX_BOTTOM, make_plane(N_MIN, '0, N_MAX, OFF_MAX));
          write_reg(IDX_NEAR,   '0);
          write_reg(IDX_FAR,    make_plane('0, N_MAX, N_MIN, '0));
        end
        default: begin
          // writes to unused indexes must not disturb the box
          load_box($urandom_range(40000, 256), $urandom_range(40000, 256),
                   $urandom_range(40000, 256));
          write_reg(IDX_SPARE_A, {$urandom, $urandom});
          write_reg(IDX_SPARE_B, '1);
        end
      endcase
      cfg_we_i <= 1'b0;
      idle_en  <= (phase_e'(ph) != PH_BOX_QUIET);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (phase_e'(ph) == PH_BOX_QUIET && k == ITEMS_PER_PHASE / 2) begin
          in_valid_i <= 1'b0;
          wait_idle();
        end
        if (phase_e'(ph) inside {PH_BOX, PH_BOX_QUIET, PH_SPARE})
          send_sphere(rand_sphere($urandom_range(99) < 85), 1'b0, 1'b0);
        else
          send_sphere(rand_sphere($urandom_range(99) < 30), 1'b0, 1'b0);
      end
      in_valid_i <= 1'b0;
    end

    wait_idle();
    $display("checked %0d spheres over %0d plane sets: %0d inside, %0d culled",
             n_sent, PH_COUNT + 2, n_inside, n_outside);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sphere_frustum_cull_top.f
+incdir+src
src/sfc_pkg.sv
src/sfc_sqrt_pipe.sv
src/sphere_frustum_cull_top.sv
tb/sv/tb_sphere_frustum_cull_top.sv
